[rtl/mfqd_pkg.sv]
package mfqd_pkg;

    // operation codes of a request
    typedef enum logic [1:0] {
        OP_LOAD     = 2'd0,
        OP_DISPATCH = 2'd1,
        OP_CLEAR    = 2'd2,
        OP_NONE     = 2'd3
    } op_t;

    // configuration register indexes
    localparam logic [2:0] CFG_NUM_LEVELS = 3'd0;
    localparam logic [2:0] CFG_QUANTUM0   = 3'd1;
    localparam logic [2:0] CFG_QUANTUM1   = 3'd2;
    localparam logic [2:0] CFG_QUANTUM2   = 3'd3;
    localparam logic [2:0] CFG_QUANTUM3   = 3'd4;

    localparam int TIME_W = 21;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SELECT,
        S_QREAD,
        S_TREAD
    } state_t;

    // one row of the process table
    typedef struct packed {
        logic [7:0]  proc_id;
        logic [15:0] arrival;
        logic [15:0] remaining;
    } tbl_entry_t;

endpackage

[rtl/mfqd_ram.sv]
module mfqd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/multilevel_feedback_queue_dispatcher.sv]
// channel   | handshake          | payload
// ----------+--------------------+------------------------------------------
// request   | start / busy       | operation, proc_id, arrival, burst
// result    | done (one cycle)   | slice_valid .. load_refused
// config    | cfg_we             | cfg_index, cfg_data
//
// load, clear and unused codes: result in the cycle after acceptance, busy stays low.
// dispatch: one pass over the process table, a second pass when time jumps to
// the next arrival, then the states S_SELECT, S_QREAD and S_TREAD for queue pop
// and table read-modify-write.
// reset clears flags, queue pointers, counters and time; no clearing pass.
// the receiver cannot stall: each result is shown for exactly one cycle.
module multilevel_feedback_queue_dispatcher #(
    parameter int MAX_PROCS  = 16,
    parameter int MAX_LEVELS = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  operation,
    input  logic [7:0]  proc_id,
    input  logic [15:0] arrival,
    input  logic [15:0] burst,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output logic        done,
    output logic        slice_valid,
    output logic [20:0] slice_begin,
    output logic [7:0]  slice_proc,
    output logic [15:0] slice_length,
    output logic [1:0]  slice_level,
    output logic        proc_finished,
    output logic        all_done,
    output logic        load_refused
);

    localparam int IW  = MAX_PROCS > 1 ? $clog2(MAX_PROCS) : 1;
    localparam int CW  = $clog2(MAX_PROCS + 1);
    localparam int LW  = MAX_LEVELS > 1 ? $clog2(MAX_LEVELS) : 1;
    localparam int QD  = MAX_LEVELS * MAX_PROCS;
    localparam int QAW = QD > 1 ? $clog2(QD) : 1;
    localparam int TW  = mfqd_pkg::TIME_W;
    localparam logic [CW-1:0]  MAXP_C  = CW'(MAX_PROCS);
    localparam logic [CW:0]    MAXP_C1 = (CW + 1)'(MAX_PROCS);
    localparam logic [IW-1:0]  LASTP   = IW'(MAX_PROCS - 1);
    localparam logic [QAW-1:0] MAXP_Q  = QAW'(MAX_PROCS);
    localparam logic [3:0]     MAXL_4  = 4'(MAX_LEVELS);

    // configuration registers
    logic [2:0]  num_levels_reg;
    logic [15:0] quantum_reg [4];

    // control state
    mfqd_pkg::state_t state_reg, state_next;
    logic [CW-1:0]  issue_reg, issue_next;
    logic           pv_reg, pv_next;
    logic [IW-1:0]  pidx_reg, pidx_next;
    logic           pass_reg, pass_next;
    logic           found_reg, found_next;
    logic [15:0]    earliest_reg, earliest_next;
    logic [TW-1:0]  time_reg, time_next;
    logic [CW-1:0]  loaded_reg, loaded_next;
    logic [CW-1:0]  fcnt_reg, fcnt_next;
    logic [MAX_PROCS-1:0] adm_reg, adm_next;
    logic [MAX_PROCS-1:0] fin_reg, fin_next;
    logic [IW-1:0]  head_reg [MAX_LEVELS];
    logic [IW-1:0]  head_next [MAX_LEVELS];
    logic [CW-1:0]  count_reg [MAX_LEVELS];
    logic [CW-1:0]  count_next [MAX_LEVELS];
    logic [LW-1:0]  lv_reg, lv_next;

    // result registers
    logic        done_reg, done_next;
    logic        sv_reg, sv_next;
    logic [20:0] ss_reg, ss_next;
    logic [7:0]  sp_reg, sp_next;
    logic [15:0] sl_reg, sl_next;
    logic [1:0]  slv_reg, slv_next;
    logic        pf_reg, pf_next;
    logic        ad_reg, ad_next;
    logic        lr_reg, lr_next;

    // memory ports
    logic                     t_we;
    logic [IW-1:0]            t_waddr, t_raddr;
    mfqd_pkg::tbl_entry_t     t_wdata, t_rdata;
    logic                     q_we;
    logic [QAW-1:0]           q_waddr, q_raddr;
    logic [IW-1:0]            q_wdata, q_rdata;

    // helpers
    logic          top_any;
    logic [LW-1:0] top_lv;
    logic [CW:0]   pos_sum;
    logic [IW-1:0] pos0;
    logic [15:0]   quant;
    logic [15:0]   run;
    logic [15:0]   new_rem;
    logic [3:0]    nl;
    logic [LW-1:0] nxt_lv;
    logic [CW:0]   npos_sum;
    logic [IW-1:0] npos;

    mfqd_ram #(.WIDTH($bits(mfqd_pkg::tbl_entry_t)), .DEPTH(MAX_PROCS)) u_table (
        .clk   (clk),
        .we    (t_we),
        .waddr (t_waddr),
        .wdata (t_wdata),
        .raddr (t_raddr),
        .rdata (t_rdata)
    );

    mfqd_ram #(.WIDTH(IW), .DEPTH(QD)) u_queues (
        .clk   (clk),
        .we    (q_we),
        .waddr (q_waddr),
        .wdata (q_wdata),
        .raddr (q_raddr),
        .rdata (q_rdata)
    );

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_levels_reg <= 3'd3;
            quantum_reg[0] <= 16'd2;
            quantum_reg[1] <= 16'd4;
            quantum_reg[2] <= 16'd8;
            quantum_reg[3] <= 16'd16;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                mfqd_pkg::CFG_NUM_LEVELS: num_levels_reg <= cfg_data[2:0];
                mfqd_pkg::CFG_QUANTUM0:   quantum_reg[0] <= cfg_data;
                mfqd_pkg::CFG_QUANTUM1:   quantum_reg[1] <= cfg_data;
                mfqd_pkg::CFG_QUANTUM2:   quantum_reg[2] <= cfg_data;
                mfqd_pkg::CFG_QUANTUM3:   quantum_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    // highest priority non-empty level
    always_comb
    begin
        top_any = 1'b0;
        top_lv  = '0;
        for (int l = MAX_LEVELS - 1; l >= 0; l--)
        begin
            if (count_reg[l] != '0)
            begin
                top_any = 1'b1;
                top_lv  = LW'(l);
            end
        end
    end

    // tail position of level 0
    always_comb
    begin
        pos_sum = {1'b0, CW'(head_reg[0])} + {1'b0, count_reg[0]};
        if (pos_sum >= MAXP_C1)
        begin
            pos_sum = pos_sum - MAXP_C1;
        end
        pos0 = pos_sum[IW-1:0];
    end

    // slice length, next level and its tail
    always_comb
    begin
        if (lv_reg == LW'(0))
            quant = quantum_reg[0];
        else if (lv_reg == LW'(1) && MAX_LEVELS > 1)
            quant = quantum_reg[1];
        else if (lv_reg == LW'(2) && MAX_LEVELS > 2)
            quant = quantum_reg[2];
        else
            quant = quantum_reg[3];
        if (quant == 16'd0)
        begin
            quant = 16'd1;
        end
        run     = (t_rdata.remaining < quant) ? t_rdata.remaining : quant;
        new_rem = t_rdata.remaining - run;
        nl = {1'b0, num_levels_reg};
        if (nl == 4'd0)
        begin
            nl = 4'd1;
        end
        if (nl > MAXL_4)
        begin
            nl = MAXL_4;
        end
        nxt_lv = (4'(lv_reg) + 4'd1 < nl) ? LW'(4'(lv_reg) + 4'd1) : lv_reg;
        npos_sum = {1'b0, CW'(head_reg[nxt_lv])} + {1'b0, count_reg[nxt_lv]};
        if (npos_sum >= MAXP_C1)
        begin
            npos_sum = npos_sum - MAXP_C1;
        end
        npos = npos_sum[IW-1:0];
    end

    // sequencer: next state, memory accesses and results
    always_comb
    begin
        state_next    = state_reg;
        issue_next    = issue_reg;
        pv_next       = 1'b0;
        pidx_next     = pidx_reg;
        pass_next     = pass_reg;
        found_next    = found_reg;
        earliest_next = earliest_reg;
        time_next     = time_reg;
        loaded_next   = loaded_reg;
        fcnt_next     = fcnt_reg;
        adm_next      = adm_reg;
        fin_next      = fin_reg;
        head_next     = head_reg;
        count_next    = count_reg;
        lv_next       = lv_reg;
        done_next     = 1'b0;
        sv_next       = 1'b0;
        ss_next       = '0;
        sp_next       = '0;
        sl_next       = '0;
        slv_next      = '0;
        pf_next       = 1'b0;
        ad_next       = ad_reg;
        lr_next       = 1'b0;
        t_we          = 1'b0;
        t_waddr       = loaded_reg[IW-1:0];
        t_wdata       = '{proc_id: proc_id, arrival: arrival, remaining: burst};
        t_raddr       = issue_reg[IW-1:0];
        q_we          = 1'b0;
        q_waddr       = QAW'(pos0);
        q_wdata       = pidx_reg;
        q_raddr       = QAW'(top_lv) * MAXP_Q + QAW'(head_reg[top_lv]);

        case (state_reg)
            mfqd_pkg::S_IDLE:
            begin
                if (start)
                begin
                    case (mfqd_pkg::op_t'(operation))
                        mfqd_pkg::OP_LOAD:
                        begin
                            done_next = 1'b1;
                            if (loaded_reg >= MAXP_C)
                            begin
                                lr_next = 1'b1;
                                ad_next = (fcnt_reg == loaded_reg);
                            end
                            else
                            begin
                                t_we = 1'b1;
                                adm_next[loaded_reg[IW-1:0]] = 1'b0;
                                fin_next[loaded_reg[IW-1:0]] = 1'b0;
                                loaded_next = loaded_reg + CW'(1);
                                ad_next = (fcnt_reg == loaded_next);
                            end
                        end
                        mfqd_pkg::OP_CLEAR:
                        begin
                            done_next   = 1'b1;
                            adm_next    = '0;
                            fin_next    = '0;
                            time_next   = '0;
                            loaded_next = '0;
                            fcnt_next   = '0;
                            for (int l = 0; l < MAX_LEVELS; l++)
                            begin
                                head_next[l]  = '0;
                                count_next[l] = '0;
                            end
                            ad_next = 1'b1;
                        end
                        mfqd_pkg::OP_DISPATCH:
                        begin
                            state_next = mfqd_pkg::S_SCAN;
                            issue_next = '0;
                            pass_next  = 1'b0;
                            found_next = 1'b0;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                            ad_next   = (fcnt_reg == loaded_reg);
                        end
                    endcase
                end
            end

            // admission pass: read one row a cycle, act on the row read last cycle
            mfqd_pkg::S_SCAN:
            begin
                if (issue_reg < loaded_reg)
                begin
                    pv_next    = 1'b1;
                    pidx_next  = issue_reg[IW-1:0];
                    issue_next = issue_reg + CW'(1);
                end
                if (pv_reg && !adm_reg[pidx_reg] && !fin_reg[pidx_reg])
                begin
                    if (TW'(t_rdata.arrival) <= time_reg)
                    begin
                        adm_next[pidx_reg] = 1'b1;
                        if (count_reg[0] < MAXP_C)
                        begin
                            q_we          = 1'b1;
                            count_next[0] = count_reg[0] + CW'(1);
                        end
                    end
                    else if (!found_reg || t_rdata.arrival < earliest_reg)
                    begin
                        found_next    = 1'b1;
                        earliest_next = t_rdata.arrival;
                    end
                end
                if (!pv_reg && issue_reg >= loaded_reg)
                begin
                    state_next = mfqd_pkg::S_SELECT;
                end
            end

            mfqd_pkg::S_SELECT:
            begin
                if (top_any)
                begin
                    lv_next = top_lv;
                    head_next[top_lv] = (head_reg[top_lv] == LASTP) ? '0
                                        : head_reg[top_lv] + IW'(1);
                    count_next[top_lv] = count_reg[top_lv] - CW'(1);
                    state_next = mfqd_pkg::S_QREAD;
                end
                else if (!pass_reg && found_reg)
                begin
                    // idle gap: jump to the earliest pending arrival
                    time_next  = TW'(earliest_reg);
                    pass_next  = 1'b1;
                    issue_next = '0;
                    state_next = mfqd_pkg::S_SCAN;
                end
                else
                begin
                    done_next  = 1'b1;
                    ad_next    = (fcnt_reg == loaded_reg);
                    state_next = mfqd_pkg::S_IDLE;
                end
            end

            mfqd_pkg::S_QREAD:
            begin
                t_raddr    = q_rdata;
                pidx_next  = q_rdata;
                state_next = mfqd_pkg::S_TREAD;
            end

            // run the slice, write back remaining, requeue or finish
            mfqd_pkg::S_TREAD:
            begin
                t_we    = 1'b1;
                t_waddr = pidx_reg;
                t_wdata = '{proc_id: t_rdata.proc_id, arrival: t_rdata.arrival,
                            remaining: new_rem};
                done_next = 1'b1;
                sv_next   = 1'b1;
                ss_next   = time_reg;
                sp_next   = t_rdata.proc_id;
                sl_next   = run;
                slv_next  = 2'(lv_reg);
                time_next = time_reg + TW'(run);
                if (new_rem != 16'd0)
                begin
                    if (count_reg[nxt_lv] < MAXP_C)
                    begin
                        q_we    = 1'b1;
                        q_waddr = QAW'(nxt_lv) * MAXP_Q + QAW'(npos);
                        count_next[nxt_lv] = count_reg[nxt_lv] + CW'(1);
                    end
                    ad_next = (fcnt_reg == loaded_reg);
                end
                else
                begin
                    fin_next[pidx_reg] = 1'b1;
                    fcnt_next = fcnt_reg + CW'(1);
                    pf_next   = 1'b1;
                    ad_next   = (fcnt_next == loaded_reg);
                end
                state_next = mfqd_pkg::S_IDLE;
            end

            default:
            begin
                state_next = mfqd_pkg::S_IDLE;
            end
        endcase
    end

    // state and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mfqd_pkg::S_IDLE;
            issue_reg <= '0;
            pv_reg    <= 1'b0;
            pass_reg  <= 1'b0;
            found_reg <= 1'b0;
            time_reg  <= '0;
            loaded_reg <= '0;
            fcnt_reg  <= '0;
            adm_reg   <= '0;
            fin_reg   <= '0;
            for (int l = 0; l < MAX_LEVELS; l++)
            begin
                head_reg[l]  <= '0;
                count_reg[l] <= '0;
            end
            done_reg  <= 1'b0;
            ad_reg    <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            issue_reg <= issue_next;
            pv_reg    <= pv_next;
            pass_reg  <= pass_next;
            found_reg <= found_next;
            time_reg  <= time_next;
            loaded_reg <= loaded_next;
            fcnt_reg  <= fcnt_next;
            adm_reg   <= adm_next;
            fin_reg   <= fin_next;
            head_reg  <= head_next;
            count_reg <= count_next;
            done_reg  <= done_next;
            ad_reg    <= ad_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        pidx_reg     <= pidx_next;
        earliest_reg <= earliest_next;
        lv_reg       <= lv_next;
        sv_reg       <= sv_next;
        ss_reg       <= ss_next;
        sp_reg       <= sp_next;
        sl_reg       <= sl_next;
        slv_reg      <= slv_next;
        pf_reg       <= pf_next;
        lr_reg       <= lr_next;
    end

    assign busy          = (state_reg != mfqd_pkg::S_IDLE);
    assign done          = done_reg;
    assign slice_valid   = sv_reg;
    assign slice_begin   = ss_reg;
    assign slice_proc    = sp_reg;
    assign slice_length  = sl_reg;
    assign slice_level   = slv_reg;
    assign proc_finished = pf_reg;
    assign all_done      = ad_reg;
    assign load_refused  = lr_reg;

`ifndef SYNTHESIS
    // never more finished than loaded
    a_fin_le_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        fcnt_reg <= loaded_reg)
        else $error("finished count above loaded count");

    // table never overfills
    a_loaded_cap: assert property (@(posedge clk) disable iff (!rst_n)
        loaded_reg <= MAXP_C)
        else $error("loaded count above capacity");

    // non-dispatch requests answer in the next cycle
    a_quick_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && operation != mfqd_pkg::OP_DISPATCH) |=> done)
        else $error("missing result for load or clear");

    // a finished flag only comes with a slice
    a_fin_slice: assert property (@(posedge clk) disable iff (!rst_n)
        (done && proc_finished) |-> slice_valid)
        else $error("finished without a slice");
`endif

endmodule

[sim/tb_multilevel_feedback_queue_dispatcher.sv]
module tb_multilevel_feedback_queue_dispatcher;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NPROC = 16;
    localparam int NLEV  = 4;

    // one dispatcher outcome
    typedef struct packed {
        logic        slice_valid;
        logic [20:0] slice_begin;
        logic [7:0]  slice_proc;
        logic [15:0] slice_length;
        logic [1:0]  slice_level;
        logic        proc_finished;
        logic        all_done;
        logic        load_refused;
    } slice_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    mfqd_pkg::op_t operation = mfqd_pkg::OP_NONE;
    logic [7:0]  proc_id = '0;
    logic [15:0] arrival = '0;
    logic [15:0] burst = '0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;
    logic        done;
    logic        slice_valid;
    logic [20:0] slice_begin;
    logic [7:0]  slice_proc;
    logic [15:0] slice_length;
    logic [1:0]  slice_level;
    logic        proc_finished;
    logic        all_done;
    logic        load_refused;

    multilevel_feedback_queue_dispatcher dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .operation(operation), .proc_id(proc_id), .arrival(arrival), .burst(burst),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .done(done), .slice_valid(slice_valid), .slice_begin(slice_begin),
        .slice_proc(slice_proc), .slice_length(slice_length),
        .slice_level(slice_level), .proc_finished(proc_finished),
        .all_done(all_done), .load_refused(load_refused)
    );

    always #5 clk = ~clk;

    // shadow of registers and scheduler state
    logic [2:0]  lvl_cfg;
    logic [15:0] quanta [NLEV];
    logic [7:0]  tbl_id [NPROC];
    logic [15:0] tbl_arr [NPROC];
    logic [15:0] tbl_rem [NPROC];
    bit          tbl_adm [NPROC];
    bit          tbl_fin [NPROC];
    int          lvl_q [NLEV][$];
    logic [20:0] now;
    int          n_loaded;
    int          n_finished;

    slice_t expected_slices [$];
    int     mismatches = 0;
    bit     quiet_idle = 1'b0;

    function automatic void clear_shadow();
        now = '0;
        n_loaded = 0;
        n_finished = 0;
        for (int i = 0; i < NLEV; i++) lvl_q[i].delete();
        for (int i = 0; i < NPROC; i++)
        begin
            tbl_adm[i] = 1'b0;
            tbl_fin[i] = 1'b0;
        end
    endfunction

    function automatic void admit();
        for (int i = 0; i < n_loaded; i++)
        begin
            if (!tbl_adm[i] && !tbl_fin[i] && tbl_arr[i] <= now)
            begin
                tbl_adm[i] = 1'b1;
                lvl_q[0].push_back(i);
            end
        end
    endfunction

    function automatic int top_lvl();
        for (int l = 0; l < NLEV; l++)
            if (lvl_q[l].size() != 0) return l;
        return -1;
    endfunction

    // work out the slice for one request and update the shadow
    function automatic slice_t schedule(mfqd_pkg::op_t op, logic [7:0] id,
                                        logic [15:0] arr, logic [15:0] bst);
        slice_t r;
        int lv, idx, nl, earliest;
        bit found;
        logic [15:0] q, run;
        r = '0;
        if (op == mfqd_pkg::OP_LOAD)
        begin
            if (n_loaded >= NPROC) r.load_refused = 1'b1;
            else
            begin
                tbl_id[n_loaded] = id;
                tbl_arr[n_loaded] = arr;
                tbl_rem[n_loaded] = bst;
                tbl_adm[n_loaded] = 1'b0;
                tbl_fin[n_loaded] = 1'b0;
                n_loaded++;
            end
        end
        else if (op == mfqd_pkg::OP_CLEAR)
            clear_shadow();
        else if (op == mfqd_pkg::OP_DISPATCH)
        begin
            admit();
            lv = top_lvl();
            if (lv < 0 && n_finished < n_loaded)
            begin
                found = 1'b0;
                earliest = 0;
                for (int i = 0; i < n_loaded; i++)
                begin
                    if (!tbl_fin[i] && !tbl_adm[i] && (!found || tbl_arr[i] < earliest))
                    begin
                        earliest = tbl_arr[i];
                        found = 1'b1;
                    end
                end
                if (found)
                begin
                    now = 21'(earliest);
                    admit();
                    lv = top_lvl();
                end
            end
            if (lv >= 0)
            begin
                idx = lvl_q[lv].pop_front();
                q = quanta[lv];
                if (q == 0) q = 16'd1;
                run = (tbl_rem[idx] < q) ? tbl_rem[idx] : q;
                nl = lvl_cfg;
                if (nl < 1) nl = 1;
                if (nl > NLEV) nl = NLEV;
                r.slice_valid = 1'b1;
                r.slice_begin = now;
                r.slice_proc = tbl_id[idx];
                r.slice_length = run;
                r.slice_level = 2'(lv);
                tbl_rem[idx] -= run;
                now = now + 21'(run);
                if (tbl_rem[idx] > 0)
                    lvl_q[(lv + 1 < nl) ? lv + 1 : lv].push_back(idx);
                else
                begin
                    tbl_fin[idx] = 1'b1;
                    n_finished++;
                    r.proc_finished = 1'b1;
                end
            end
        end
        r.all_done = (n_finished == n_loaded);
        return r;
    endfunction

    // check each result against the oldest expectation
    always @(posedge clk)
    begin
        slice_t got, want;
        if (rst_n && done)
        begin
            got = {slice_valid, slice_begin, slice_proc, slice_length, slice_level,
                   proc_finished, all_done, load_refused};
            if (expected_slices.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", got);
            end
            else
            begin
                want = expected_slices.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("mismatch: expected v%0b t%0d p%0d l%0d lv%0d f%0b a%0b r%0b",
                            want.slice_valid, want.slice_begin, want.slice_proc,
                            want.slice_length, want.slice_level, want.proc_finished,
                            want.all_done, want.load_refused);
                        $display("          got      v%0b t%0d p%0d l%0d lv%0d f%0b a%0b r%0b",
                            got.slice_valid, got.slice_begin, got.slice_proc,
                            got.slice_length, got.slice_level, got.proc_finished,
                            got.all_done, got.load_refused);
                    end
                end
            end
        end
    end

    // send one request, with random idle cycles ahead of it unless quiet_idle is set
    task automatic send_request(mfqd_pkg::op_t op, logic [7:0] id, logic [15:0] arr,
                                logic [15:0] bst);
        while (!quiet_idle && $urandom_range(99) < 18)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        operation <= op;
        proc_id <= id;
        arrival <= arr;
        burst <= bst;
        @(posedge clk);
        while (busy) @(posedge clk);
        expected_slices.push_back(schedule(op, id, arr, bst));
    endtask

    // wait until idle, then write one register
    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        start <= 1'b0;
        while (expected_slices.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == mfqd_pkg::CFG_NUM_LEVELS) lvl_cfg = val[2:0];
        else if (idx <= mfqd_pkg::CFG_QUANTUM3) quanta[2'(idx - 3'd1)] = val;
    endtask

    task automatic test_directed();
        write_reg(mfqd_pkg::CFG_NUM_LEVELS, 16'd4);
        write_reg(mfqd_pkg::CFG_QUANTUM0, 16'd0);
        write_reg(mfqd_pkg::CFG_QUANTUM1, 16'd3);
        write_reg(mfqd_pkg::CFG_QUANTUM2, 16'd5);
        write_reg(mfqd_pkg::CFG_QUANTUM3, 16'hFFFF);
        send_request(mfqd_pkg::OP_DISPATCH, 8'd0, 16'd0, 16'd0);
        send_request(mfqd_pkg::OP_LOAD, 8'hFF, 16'hFFFF, 16'hFFFF);
        send_request(mfqd_pkg::OP_LOAD, 8'h00, 16'd0, 16'd0);
        send_request(mfqd_pkg::OP_LOAD, 8'h5A, 16'd3, 16'd7);
        send_request(mfqd_pkg::OP_NONE, 8'hA5, 16'h1234, 16'h4321);
        repeat (8) send_request(mfqd_pkg::OP_DISPATCH, 8'd0, 16'd0, 16'd0);
        for (int i = 0; i < 14; i++)
            send_request(mfqd_pkg::OP_LOAD, 8'(i), 16'(i), 16'(i + 1));
        send_request(mfqd_pkg::OP_CLEAR, 8'd0, 16'd0, 16'd0);
        write_reg(mfqd_pkg::CFG_NUM_LEVELS, 16'd0);
        send_request(mfqd_pkg::OP_LOAD, 8'd9, 16'd0, 16'd5);
        repeat (4) send_request(mfqd_pkg::OP_DISPATCH, 8'd0, 16'd0, 16'd0);
    endtask

    // random workloads: loads and dispatches mixed, with late loads, clears and noise
    task automatic test_random(int n_req);
        int sent;
        int pick;
        sent = 0;
        while (sent < n_req)
        begin
            quiet_idle = (sent > n_req / 3 && sent < n_req / 2);
            if (sent % 150 == 0)
            begin
                write_reg(mfqd_pkg::CFG_NUM_LEVELS, 16'($urandom_range(7)));
                write_reg(mfqd_pkg::CFG_QUANTUM0,
                          (sent % 300 == 0) ? 16'hFFFF : 16'($urandom_range(6)));
                write_reg(mfqd_pkg::CFG_QUANTUM1, 16'($urandom_range(10)));
                write_reg(mfqd_pkg::CFG_QUANTUM2,
                          (sent % 300 == 0) ? 16'd1 : 16'($urandom_range(20)));
                write_reg(mfqd_pkg::CFG_QUANTUM3, 16'($urandom_range(40)));
            end
            pick = $urandom_range(99);
            if (pick < 3)
                send_request(mfqd_pkg::OP_CLEAR, 8'($urandom), 16'($urandom),
                             16'($urandom));
            else if (pick < 5)
                send_request(mfqd_pkg::OP_NONE, 8'($urandom), 16'($urandom),
                             16'($urandom));
            else if (pick < 35)
                send_request(mfqd_pkg::OP_LOAD, 8'($urandom),
                             ($urandom_range(9) == 0) ? 16'($urandom)
                                                      : 16'($urandom_range(60)),
                             ($urandom_range(9) == 0) ? 16'($urandom)
                                                      : 16'($urandom_range(30)));
            else
                send_request(mfqd_pkg::OP_DISPATCH, 8'($urandom), 16'($urandom),
                             16'($urandom));
            sent++;
        end
        quiet_idle = 1'b0;
    endtask

    initial
    begin
        lvl_cfg = 3'd3;
        quanta[0] = 16'd2;
        quanta[1] = 16'd4;
        quanta[2] = 16'd8;
        quanta[3] = 16'd16;
        clear_shadow();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(700);
        start <= 1'b0;
        while (expected_slices.size() != 0) @(posedge clk);
        repeat (50) @(posedge clk);
        if (mismatches == 0 && expected_slices.size() == 0)
            $display("[multilevel_feedback_queue_dispatcher] OK");
        else
            $display("[multilevel_feedback_queue_dispatcher] ERROR");
        $finish;
    end

    // run limit
    initial
    begin
        #5ms;
        $display("[multilevel_feedback_queue_dispatcher] ERROR");
        $finish;
    end

endmodule
